### rtl/rvbc_pkg.sv
// Package with the shared types and constants of the raw video to BGRA converter.
package rvbc_pkg;

  // Source pixel formats.
  localparam logic [1:0] FMT_RGB24  = 2'd0;
  localparam logic [1:0] FMT_RGB32  = 2'd1;
  localparam logic [1:0] FMT_ARGB32 = 2'd2;
  localparam logic [1:0] FMT_YUY2   = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE   = 2'd3;
  localparam int unsigned CFG_DATA_W = 14;

  // Reset values of the registers.
  localparam logic [11:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
  localparam logic [13:0] RST_ROW_STRIDE   = 14'd1920;

  // Integer BT.601 coefficients and offsets.
  localparam logic signed [19:0] K_Y     = 20'sd298;
  localparam logic signed [19:0] K_U_B   = 20'sd516;
  localparam logic signed [19:0] K_U_G   = 20'sd100;
  localparam logic signed [19:0] K_V_G   = 20'sd208;
  localparam logic signed [19:0] K_V_R   = 20'sd409;
  localparam logic signed [19:0] K_ROUND = 20'sd128;
  localparam logic signed [9:0]  OFS_Y   = 10'sd16;
  localparam logic signed [9:0]  OFS_UV  = 10'sd128;
  localparam logic [7:0]         OPAQUE  = 8'hFF;

  localparam int unsigned COORD_W = 11;

  // A pixel after position tracking, before color conversion. For RGB sources
  // p0..p2 are blue, green, red; for YUY2 they are Y, U and V.
  typedef struct packed {
    logic               is_yuv;
    logic [7:0]         p0;
    logic [7:0]         p1;
    logic [7:0]         p2;
    logic [7:0]         alpha;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               frame_end;
    logic               last;
  } pix_t;

  // A finished result item.
  typedef struct packed {
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic [7:0]         alpha;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               frame_end;
    logic               last;
  } res_t;

endpackage

### rtl/raw_video_to_bgra_converter.sv
// Raw video byte stream to BGRA pixel converter, top level.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_stall    in_data_byte, in_frame_start
//   out_     output     out_valid / out_stall  out_blue .. out_alpha, out_column,
//                                              out_texture_row, out_frame_end, out_last
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte item is taken per cycle while in_stall is low. The first stage tracks
// its position and registers it; the second does the YUV to RGB arithmetic as it
// is written to the four-entry result queue, which sets the rate: input stalls
// only while the queue plus the items in flight could not take two more results.
// Synchronous reset restores the register defaults and clears pipeline and queue.
module raw_video_to_bgra_converter
  import rvbc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048,
  parameter int unsigned MAX_STRIDE = 8192
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Byte input.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_frame_start,
  // Pixel output.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_green,
  output logic [7:0]            out_red,
  output logic [7:0]            out_alpha,
  output logic [COORD_W-1:0]    out_column,
  output logic [COORD_W-1:0]    out_texture_row,
  output logic                  out_frame_end,
  output logic                  out_last,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Column, row and stride counter widths follow the maxima. The row byte
  // counter covers the longest possible row, which is the larger of four bytes
  // per pixel at the widest frame and the widest stride.
  localparam int unsigned CW     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW     = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned SW     = $clog2(MAX_STRIDE + 1);
  localparam int unsigned RE_MAX = (4 * MAX_WIDTH > MAX_STRIDE) ? 4 * MAX_WIDTH : MAX_STRIDE;
  localparam int unsigned BW     = $clog2(RE_MAX);
  localparam int unsigned EW     = BW + 1;
  localparam int unsigned PW     = RW + 2;

  // Configuration registers.
  logic [1:0]  pixel_format_r;
  logic [11:0] frame_width_r;
  logic [11:0] frame_height_r;
  logic [13:0] row_stride_r;

  // Position state.
  logic [1:0]    group_phase_r, group_phase_nxt;
  logic [23:0]   held_bytes_r, held_bytes_nxt;
  logic [CW-1:0] pixel_column_r, pixel_column_nxt;
  logic [RW-1:0] source_row_r, source_row_nxt;
  logic [BW-1:0] row_byte_pos_r, row_byte_pos_nxt;

  // First pipeline stage: up to two tracked pixels.
  logic [1:0] s1_n_r, s1_n_nxt;
  pix_t       s1_pix_r [2];
  pix_t       s1_pix_nxt [2];

  // Result queue.
  res_t       fifo_mem_r [4];
  logic [1:0] wr_ptr_r;
  logic [1:0] rd_ptr_r;
  logic [2:0] cnt_r;

  logic in_acc;
  logic out_acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r <= FMT_RGB24;
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      row_stride_r   <= RST_ROW_STRIDE;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PIXEL_FORMAT: pixel_format_r <= cfg_data[1:0];
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[11:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[11:0];
        CFG_ROW_STRIDE:   row_stride_r   <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // The queue may receive two results from the first stage while the ones
  // already in flight land, so intake stops once that could overflow.
  assign in_stall = ({1'b0, cnt_r} + {2'b00, s1_n_r}) > 4'd2;
  assign in_acc   = in_valid && !in_stall;

  // Effective register values: zero acts as one, anything beyond the maximum
  // acts as the maximum.
  logic [CW-1:0] w_lim;
  logic [RW-1:0] h_lim;
  logic [SW-1:0] s_lim;

  always_comb begin
    if (frame_width_r == 12'd0) begin
      w_lim = CW'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_lim = CW'(MAX_WIDTH);
    end else begin
      w_lim = CW'(frame_width_r);
    end
    if (frame_height_r == 12'd0) begin
      h_lim = RW'(1);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      h_lim = RW'(MAX_HEIGHT);
    end else begin
      h_lim = RW'(frame_height_r);
    end
    if (row_stride_r == 14'd0) begin
      s_lim = SW'(1);
    end else if (32'(row_stride_r) > MAX_STRIDE) begin
      s_lim = SW'(MAX_STRIDE);
    end else begin
      s_lim = SW'(row_stride_r);
    end
  end

  // Steps a column by one pixel; the top bit tells that the row wrapped.
  function automatic logic [CW:0] adv_col(input logic [CW-1:0] c, input logic [CW-1:0] wl);
    logic [CW:0] r;
    if ((CW + 1)'(c) + (CW + 1)'(1) >= (CW + 1)'(wl)) begin
      r = {1'b1, {CW{1'b0}}};
    end else begin
      r = {1'b0, c + CW'(1)};
    end
    return r;
  endfunction

  // Position tracking and pixel assembly for the accepted byte.
  always_comb begin
    logic [1:0]    ph;
    logic [23:0]   hb;
    logic [CW-1:0] pc;
    logic [RW-1:0] sr;
    logic [BW-1:0] rbp;
    logic [CW:0]   a2, a3, a4;
    logic [PW-1:0] r1, r2, r3, r4;
    logic [CW-1:0] c1;
    logic [1:0]    bpp_m1;
    logic          bpp3;
    logic [EW-1:0] wb, row_end;
    logic [31:0]   trow, tcol;

    a2 = '0;
    a3 = '0;
    a4 = '0;
    r1 = '0;
    r2 = '0;
    r3 = '0;
    r4 = '0;
    c1 = '0;
    bpp_m1 = '0;
    bpp3 = 1'b0;
    wb = '0;
    row_end = '0;
    trow = '0;
    tcol = '0;

    // A frame start clears the position before this byte is used.
    if (in_frame_start) begin
      ph  = '0;
      hb  = '0;
      pc  = '0;
      sr  = '0;
      rbp = '0;
    end else begin
      ph  = group_phase_r;
      hb  = held_bytes_r;
      pc  = pixel_column_r;
      sr  = source_row_r;
      rbp = row_byte_pos_r;
    end

    group_phase_nxt  = ph;
    held_bytes_nxt   = hb;
    pixel_column_nxt = pc;
    source_row_nxt   = sr;
    row_byte_pos_nxt = rbp;
    s1_n_nxt         = 2'd0;
    s1_pix_nxt[0]    = '0;
    s1_pix_nxt[1]    = '0;

    if (pixel_format_r == FMT_YUY2) begin
      if (ph != 2'd3) begin
        case (ph)
          2'd0:    held_bytes_nxt[7:0]   = in_data_byte;
          2'd1:    held_bytes_nxt[15:8]  = in_data_byte;
          default: held_bytes_nxt[23:16] = in_data_byte;
        endcase
        group_phase_nxt = ph + 2'd1;
      end else begin
        group_phase_nxt = 2'd0;
        // A column left past a narrowed width wraps first; the row counter
        // saturates, which is past every reachable height.
        if (pc >= w_lim) begin
          pc = '0;
          if (sr != {RW{1'b1}}) begin
            sr = sr + RW'(1);
          end
        end
        c1 = pc;
        r1 = PW'(sr);
        a2 = adv_col(c1, w_lim);
        r2 = r1 + PW'(a2[CW]);
        a3 = adv_col(a2[CW-1:0], w_lim);
        r3 = r2 + PW'(a3[CW]);
        a4 = adv_col(a3[CW-1:0], w_lim);
        r4 = r3 + PW'(a4[CW]);
        pixel_column_nxt = pc;
        source_row_nxt   = sr;
        // The pair is sent only when both pixels lie inside the frame.
        if (r2 < PW'(h_lim)) begin
          s1_n_nxt = 2'd2;
          tcol = 32'(c1);
          trow = 32'(r1);
          s1_pix_nxt[0].is_yuv    = 1'b1;
          s1_pix_nxt[0].p0        = hb[7:0];
          s1_pix_nxt[0].p1        = hb[15:8];
          s1_pix_nxt[0].p2        = in_data_byte;
          s1_pix_nxt[0].alpha     = OPAQUE;
          s1_pix_nxt[0].col       = tcol[COORD_W-1:0];
          s1_pix_nxt[0].row       = trow[COORD_W-1:0];
          s1_pix_nxt[0].frame_end = 1'b0;
          s1_pix_nxt[0].last      = 1'b0;
          tcol = 32'(a2[CW-1:0]);
          trow = 32'(r2);
          s1_pix_nxt[1].is_yuv    = 1'b1;
          s1_pix_nxt[1].p0        = hb[23:16];
          s1_pix_nxt[1].p1        = hb[15:8];
          s1_pix_nxt[1].p2        = in_data_byte;
          s1_pix_nxt[1].alpha     = OPAQUE;
          s1_pix_nxt[1].col       = tcol[COORD_W-1:0];
          s1_pix_nxt[1].row       = trow[COORD_W-1:0];
          s1_pix_nxt[1].frame_end = (r4 >= PW'(h_lim));
          s1_pix_nxt[1].last      = 1'b1;
          pixel_column_nxt = a3[CW-1:0];
          source_row_nxt   = r3[RW-1:0];
        end
      end
    end else if (sr < h_lim) begin
      bpp3    = (pixel_format_r == FMT_RGB24);
      bpp_m1  = bpp3 ? 2'd2 : 2'd3;
      wb      = bpp3 ? (EW'(w_lim) << 1) + EW'(w_lim) : EW'(w_lim) << 2;
      row_end = (wb > EW'(s_lim)) ? wb : EW'(s_lim);
      if (pc < w_lim) begin
        if (ph >= bpp_m1) begin
          s1_n_nxt = 2'd1;
          tcol = 32'(pc);
          trow = 32'(h_lim - RW'(1) - sr);
          s1_pix_nxt[0].is_yuv    = 1'b0;
          s1_pix_nxt[0].p0        = hb[7:0];
          s1_pix_nxt[0].p1        = hb[15:8];
          s1_pix_nxt[0].p2        = bpp3 ? in_data_byte : hb[23:16];
          s1_pix_nxt[0].alpha     = (pixel_format_r == FMT_ARGB32) ? in_data_byte : OPAQUE;
          s1_pix_nxt[0].col       = tcol[COORD_W-1:0];
          s1_pix_nxt[0].row       = trow[COORD_W-1:0];
          s1_pix_nxt[0].frame_end = ((CW + 1)'(pc) + (CW + 1)'(1) == (CW + 1)'(w_lim)) &&
                                    ((RW + 1)'(sr) + (RW + 1)'(1) == (RW + 1)'(h_lim));
          s1_pix_nxt[0].last      = 1'b1;
          pixel_column_nxt = pc + CW'(1);
          group_phase_nxt  = 2'd0;
        end else begin
          case (ph)
            2'd0:    held_bytes_nxt[7:0]   = in_data_byte;
            2'd1:    held_bytes_nxt[15:8]  = in_data_byte;
            default: held_bytes_nxt[23:16] = in_data_byte;
          endcase
          group_phase_nxt = ph + 2'd1;
        end
      end
      // The row ends after the later of the stride and its last pixel byte.
      if (EW'(rbp) + EW'(1) >= row_end) begin
        row_byte_pos_nxt = '0;
        pixel_column_nxt = '0;
        group_phase_nxt  = 2'd0;
        source_row_nxt   = sr + RW'(1);
      end else begin
        row_byte_pos_nxt = rbp + BW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_phase_r  <= '0;
      held_bytes_r   <= '0;
      pixel_column_r <= '0;
      source_row_r   <= '0;
      row_byte_pos_r <= '0;
      s1_n_r         <= '0;
    end else begin
      if (in_acc) begin
        group_phase_r  <= group_phase_nxt;
        held_bytes_r   <= held_bytes_nxt;
        pixel_column_r <= pixel_column_nxt;
        source_row_r   <= source_row_nxt;
        row_byte_pos_r <= row_byte_pos_nxt;
      end
      s1_n_r <= in_acc ? s1_n_nxt : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r[0] <= s1_pix_nxt[0];
      s1_pix_r[1] <= s1_pix_nxt[1];
    end
  end

  // Scales down a rounded color sum and clamps it to a byte.
  function automatic logic [7:0] clamp8(input logic signed [19:0] s);
    logic [7:0] r;
    if (s < 0) begin
      r = 8'd0;
    end else if (s[19:16] != 4'd0) begin
      r = 8'hFF;
    end else begin
      r = s[15:8];
    end
    return r;
  endfunction

  // Second stage: BT.601 conversion for YUY2 pixels, pass-through for RGB.
  function automatic res_t convert(input pix_t p);
    res_t              r;
    logic signed [9:0]  c, d, e;
    logic signed [19:0] yc, sb, sg, sr;
    c  = $signed({2'b00, p.p0}) - OFS_Y;
    d  = $signed({2'b00, p.p1}) - OFS_UV;
    e  = $signed({2'b00, p.p2}) - OFS_UV;
    yc = K_Y * 20'(c);
    sb = yc + K_U_B * 20'(d) + K_ROUND;
    sg = yc - K_U_G * 20'(d) - K_V_G * 20'(e) + K_ROUND;
    sr = yc + K_V_R * 20'(e) + K_ROUND;
    if (p.is_yuv) begin
      r.blue  = clamp8(sb);
      r.green = clamp8(sg);
      r.red   = clamp8(sr);
    end else begin
      r.blue  = p.p0;
      r.green = p.p1;
      r.red   = p.p2;
    end
    r.alpha     = p.alpha;
    r.col       = p.col;
    r.row       = p.row;
    r.frame_end = p.frame_end;
    r.last      = p.last;
    return r;
  endfunction

  res_t conv0, conv1;
  assign conv0 = convert(s1_pix_r[0]);
  assign conv1 = convert(s1_pix_r[1]);

  assign out_valid = (cnt_r != 3'd0);
  assign out_acc   = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (s1_n_r != 2'd0) begin
      fifo_mem_r[wr_ptr_r] <= conv0;
    end
    if (s1_n_r == 2'd2) begin
      fifo_mem_r[wr_ptr_r + 2'd1] <= conv1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + s1_n_r;
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      cnt_r <= cnt_r + {1'b0, s1_n_r} - {2'b00, out_acc};
    end
  end

  res_t head;
  assign head            = fifo_mem_r[rd_ptr_r];
  assign out_blue        = head.blue;
  assign out_green       = head.green;
  assign out_red         = head.red;
  assign out_alpha       = head.alpha;
  assign out_column      = head.col;
  assign out_texture_row = head.row;
  assign out_frame_end   = head.frame_end;
  assign out_last        = head.last;

endmodule
